/* rtl/hdd_pkg.sv */
`timescale 1ns / 1ps

package hdd_pkg;

    localparam logic [2:0] CLS_R     = 3'd0;
    localparam logic [2:0] CLS_LDST  = 3'd1;
    localparam logic [2:0] CLS_BRIMM = 3'd2;

    typedef struct packed {
        logic       sequence_start;
        logic [2:0] instr_class;
        logic       is_load_word;
        logic       is_move_from_hilo;
        logic       shift_has_amount;
        logic [4:0] reg_first;
        logic [4:0] reg_second;
        logic [4:0] reg_third;
    } item_t;

    typedef struct packed {
        logic       prev1_valid;
        logic [2:0] prev1_class;
        logic       prev1_is_load;
        logic [4:0] prev1_reg;
        logic       prev2_valid;
        logic [2:0] prev2_class;
        logic [4:0] prev2_reg;
        logic       sticky_load_use;
        logic       sticky_nofwd;
    } hist_t;

    typedef struct packed {
        logic any_nofwd_seen;
        logic any_load_use_seen;
        logic nofwd_hazard_far;
        logic nofwd_hazard_near;
        logic load_use_hazard;
    } result_t;

endpackage

/* rtl/hdd_check.sv */
`timescale 1ns / 1ps

module hdd_check (
    input  hdd_pkg::item_t   item,
    input  hdd_pkg::hist_t   hist,
    output hdd_pkg::result_t result,
    output hdd_pkg::hist_t   hist_next
);

    function automatic logic reads_reg(input hdd_pkg::item_t it, input logic [4:0] w);
        logic hit;
        begin
            hit = 1'b0;
            case (it.instr_class)
                hdd_pkg::CLS_R: begin
                    hit = !it.is_move_from_hilo &&
                          ((it.reg_second == w) || (!it.shift_has_amount && it.reg_third == w));
                end
                hdd_pkg::CLS_LDST: begin
                    hit = (it.reg_second == w);
                end
                hdd_pkg::CLS_BRIMM: begin
                    hit = (it.reg_first == w) || (it.reg_second == w);
                end
                default: begin
                    hit = 1'b0;
                end
            endcase
            return hit;
        end
    endfunction

    hdd_pkg::hist_t h;
    logic           lu;
    logic           near_hit;
    logic           far_hit;

    always_comb begin
        h = hist;
        // a new sequence forgets history and sticky flags before checking
        if (item.sequence_start) begin
            h.prev1_valid     = 1'b0;
            h.prev2_valid     = 1'b0;
            h.sticky_load_use = 1'b0;
            h.sticky_nofwd    = 1'b0;
        end

        lu       = h.prev1_valid && h.prev1_is_load && reads_reg(item, h.prev1_reg);
        near_hit = h.prev1_valid && (h.prev1_class == hdd_pkg::CLS_R) &&
                   reads_reg(item, h.prev1_reg);
        far_hit  = h.prev2_valid && (h.prev2_class == hdd_pkg::CLS_R) &&
                   reads_reg(item, h.prev2_reg);

        hist_next.sticky_load_use = h.sticky_load_use || lu;
        hist_next.sticky_nofwd    = h.sticky_nofwd || near_hit || far_hit;
        hist_next.prev2_valid     = h.prev1_valid;
        hist_next.prev2_class     = h.prev1_class;
        hist_next.prev2_reg       = h.prev1_reg;
        hist_next.prev1_valid     = 1'b1;
        hist_next.prev1_class     = item.instr_class;
        hist_next.prev1_is_load   = item.is_load_word;
        hist_next.prev1_reg       = item.reg_first;

        result.load_use_hazard   = lu;
        result.nofwd_hazard_near = near_hit;
        result.nofwd_hazard_far  = far_hit;
        result.any_load_use_seen = hist_next.sticky_load_use;
        result.any_nofwd_seen    = hist_next.sticky_nofwd;
    end

endmodule

/* rtl/pipeline_data_hazard_detector.sv */
`timescale 1ns / 1ps

// Data hazard detector for a five-stage pipeline.
// The s_axis channel carries one decoded instruction per word; the m_axis
// channel returns one word of hazard flags for every instruction, in order.
// The block remembers the class and first register of the two previous
// instructions, the load flag of the previous one, and two sticky flags;
// a word with sequence_start set clears that history before it is checked.
// Path: a word accepted on s_axis is registered, checked against the
// history, and its flags are registered again and presented on m_axis.
// Throughput: one word per cycle while m_axis_tready is high, set by the
// single compare stage that checks the registered word against the two
// history entries.
// Reset: aresetn low clears both stage valids, the history and the sticky
// flags; s_axis_tready is high again in the first cycle after reset.
// Stall: while m_axis_tready is low the result word holds; the input
// register takes at most one more word, after which s_axis_tready drops.
module pipeline_data_hazard_detector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sequence_start, reg_first, reg_second, reg_third
    input  logic [15:0] s_axis_tdata,
    // instr_class, is_load_word, is_move_from_hilo, shift_has_amount
    input  logic [5:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // load_use_hazard, nofwd_hazard_near, nofwd_hazard_far,
    // any_load_use_seen, any_nofwd_seen, 3 bits zero
    output logic [7:0]  m_axis_tdata
);

    logic             in_valid_reg;
    hdd_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    hdd_pkg::result_t out_result_reg;
    hdd_pkg::hist_t   hist_reg;
    hdd_pkg::hist_t   hist_next;
    hdd_pkg::result_t result_next;
    hdd_pkg::item_t   s_item;
    logic             out_advance;
    logic             in_advance;

    assign out_advance   = !out_valid_reg || m_axis_tready;
    assign in_advance    = !in_valid_reg || out_advance;
    assign s_axis_tready = in_advance;

    always_comb begin
        s_item.sequence_start    = s_axis_tdata[0];
        s_item.reg_first         = s_axis_tdata[5:1];
        s_item.reg_second        = s_axis_tdata[10:6];
        s_item.reg_third         = s_axis_tdata[15:11];
        s_item.instr_class       = s_axis_tuser[2:0];
        s_item.is_load_word      = s_axis_tuser[3];
        s_item.is_move_from_hilo = s_axis_tuser[4];
        s_item.shift_has_amount  = s_axis_tuser[5];
    end

    hdd_check u_check (
        .item      (in_item_reg),
        .hist      (hist_reg),
        .result    (result_next),
        .hist_next (hist_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_reg      <= '0;
        end else begin
            if (in_advance) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    hist_reg <= hist_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance && s_axis_tvalid) begin
            in_item_reg <= s_item;
        end
        if (out_advance && in_valid_reg) begin
            out_result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_result_reg};

endmodule

/* rtl/hdd_checker.sv */
`timescale 1ns / 1ps

module hdd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // no result word right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result word valid after reset");

    // stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // a load-use hazard shows in the sticky flag of the same word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[3])
        else $error("load-use hazard without sticky flag");

    // a no-forwarding hazard shows in the sticky flag of the same word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[1] || m_axis_tdata[2]) |-> m_axis_tdata[4])
        else $error("no-forwarding hazard without sticky flag");

    // an empty block always takes a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid && $past(!s_axis_tvalid) && $past(aresetn) |-> s_axis_tready)
        else $error("input stalled while block empty");

endmodule

bind pipeline_data_hazard_detector hdd_checker u_hdd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
